>>> rtl/triggered_sample_recorder_defines.svh
// Assertion macros used by the recorder state module (trs_step).
`ifndef TRIGGERED_SAMPLE_RECORDER_DEFINES_SVH
`define TRIGGERED_SAMPLE_RECORDER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define TRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define TRS_ASSERT_NEVER(label, clk, rst_n, expr) \
    `TRS_ASSERT(label, clk, rst_n, !(expr))

`endif

>>> rtl/trs_pkg.sv
// Types and constants of the triggered sample recorder.
`timescale 1ns / 1ps

package trs_pkg;

    localparam int DATA_W       = 64;
    localparam int SLOT_FIELD_W = 12;
    localparam int TRIG_W       = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int TOTAL_W      = 13;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_CFG     = 2'd1,
        ST_RUNNING     = 2'd2,
        ST_STOPPED     = 2'd3
    } status_t;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_FALLING = 2'd2;

    localparam logic [2:0] CMP_S8  = 3'd0;
    localparam logic [2:0] CMP_U8  = 3'd1;
    localparam logic [2:0] CMP_S16 = 3'd2;
    localparam logic [2:0] CMP_U16 = 3'd3;
    localparam logic [2:0] CMP_S32 = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONFIGURED    = 3'd0,
        REG_TRIGGER_MODE  = 3'd1,
        REG_COMPARE_TYPE  = 3'd2,
        REG_THRESHOLD     = 3'd3,
        REG_TIME_DIV      = 3'd4,
        REG_POST_TRIGGER  = 3'd5,
        REG_TOTAL_SAMPLES = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic               configured;
        logic [1:0]         trigger_mode;
        logic [2:0]         compare_type;
        logic [TRIG_W-1:0]  threshold;
        logic [15:0]        time_div;
        logic [15:0]        post_trigger;
        logic [TOTAL_W-1:0] total_samples;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        configured:    1'b0,
        trigger_mode:  2'd0,
        compare_type:  3'd0,
        threshold:     {TRIG_W{1'b0}},
        time_div:      16'd0,
        post_trigger:  16'd0,
        total_samples: TOTAL_RESET
    };

    typedef struct packed {
        status_t                 status;
        logic                    write_enable;
        logic [SLOT_FIELD_W-1:0] write_slot;
        logic [DATA_W-1:0]       write_data;
        logic                    is_running;
        logic                    is_triggered;
        logic [SLOT_FIELD_W-1:0] oldest_slot;
    } res_t;

endpackage

>>> rtl/triggered_sample_recorder.sv
// Top level of the triggered sample recorder: stream handshake and pipeline registers.
//
// Usage:
//   Input beats on s_*: func in s_tuser (tick, start, stop); each tick carries a
//   sample word and a trigger value in s_tdata. Every accepted input beat yields
//   exactly one result beat on m_*, in order: status in m_tuser, write strobe,
//   slot, sample word and recorder flags in m_tdata.
//   Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data, one
//   register per beat; cfg_ready is always high. Write only while idle.
// Timing:
//   Input register, combinational state update logic, output register.
//   One beat per cycle is sustained while m_tready is high.
// Reset:
//   aresetn is synchronous, active low; clears the valid flags of both pipeline stages,
//   the recorder state and the configuration (sample count back to 4096).
// Backpressure:
//   A stalled m_tready holds the result; one more input beat is absorbed in the
//   input register, then s_tready drops until the result is taken.
`timescale 1ns / 1ps

module triggered_sample_recorder
    import trs_pkg::*;
#(
    parameter int SLOT_COUNT  = 4096,
    parameter int SAMPLE_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [95:0]           s_tdata,   // sample_data[63:0], trigger_value[95:64]
    input  logic [1:0]            s_tuser,   // func[1:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata,   // write_enable[0], write_slot[12:1],
                                             // write_data[76:13], is_running[77],
                                             // is_triggered[78], oldest_slot[90:79], zero
    output logic [1:0]            m_tuser,   // status[1:0]

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t res;

    logic                   in_valid_reg,  in_valid_next;
    logic [1:0]             in_func_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic [TRIG_W-1:0]      in_trig_reg;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_res_reg;
    logic                   advance;
    logic                   s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    trs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trs_step #(
        .SLOT_COUNT  (SLOT_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .func    (in_func_reg),
        .sample  (in_sample_reg),
        .trig    (in_trig_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_func_reg   <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_trig_reg   <= s_tdata[95:64];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {5'b0,
                       out_res_reg.oldest_slot,
                       out_res_reg.is_triggered,
                       out_res_reg.is_running,
                       out_res_reg.write_data,
                       out_res_reg.write_slot,
                       out_res_reg.write_enable};

endmodule

>>> rtl/trs_trigger_cmp.sv
// Trigger threshold compare: value at or above threshold per compare type.
`timescale 1ns / 1ps

module trs_trigger_cmp
    import trs_pkg::*;
(
    input  logic [2:0]        compare_type,
    input  logic [TRIG_W-1:0] value,
    input  logic [TRIG_W-1:0] threshold,
    output logic              at_or_above
);

    logic [TRIG_W-1:0] mask;
    logic [TRIG_W-1:0] sign;

    always_comb begin
        unique case (compare_type)
            CMP_S8:  begin mask = 32'h0000_00FF; sign = 32'h0000_0080; end
            CMP_U8:  begin mask = 32'h0000_00FF; sign = 32'h0000_0000; end
            CMP_S16: begin mask = 32'h0000_FFFF; sign = 32'h0000_8000; end
            CMP_U16: begin mask = 32'h0000_FFFF; sign = 32'h0000_0000; end
            CMP_S32: begin mask = 32'hFFFF_FFFF; sign = 32'h8000_0000; end
            default: begin mask = 32'hFFFF_FFFF; sign = 32'h0000_0000; end
        endcase
    end

    assign at_or_above = ((value & mask) ^ sign) >= ((threshold & mask) ^ sign);

endmodule

>>> rtl/trs_cfg_regs.sv
// Configuration register file of the recorder.
`timescale 1ns / 1ps

module trs_cfg_regs
    import trs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_CONFIGURED:    cfg_next.configured    = cfg_data[0];
                REG_TRIGGER_MODE:  cfg_next.trigger_mode  = cfg_data[1:0];
                REG_COMPARE_TYPE:  cfg_next.compare_type  = cfg_data[2:0];
                REG_THRESHOLD:     cfg_next.threshold     = cfg_data;
                REG_TIME_DIV:      cfg_next.time_div      = cfg_data[15:0];
                REG_POST_TRIGGER:  cfg_next.post_trigger  = cfg_data[15:0];
                REG_TOTAL_SAMPLES: cfg_next.total_samples = cfg_data[TOTAL_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/trs_step.sv
// Recorder state and the per-beat update: divider, slot index, trigger, countdown.
`timescale 1ns / 1ps

`include "triggered_sample_recorder_defines.svh"

module trs_step
    import trs_pkg::*;
#(
    parameter int SLOT_COUNT  = 4096,
    parameter int SAMPLE_BITS = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic [1:0]             func,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [TRIG_W-1:0]      trig,
    input  cfg_t                   cfg,
    output res_t                   res
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int LIM_W  = $clog2(SLOT_COUNT + 1);
    localparam int CW     = (LIM_W > TOTAL_W) ? LIM_W : TOTAL_W;
    localparam int SX_W   = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;

    logic [SLOT_W-1:0] next_slot_reg,      next_slot_next;
    logic [15:0]       divider_count_reg,  divider_count_next;
    logic [15:0]       stop_countdown_reg, stop_countdown_next;
    logic              running_reg,        running_next;
    logic              stopping_reg,       stopping_next;
    logic              below_seen_reg,     below_seen_next;
    logic              first_pass_reg,     first_pass_next;

    logic              at_or_above;
    logic              crossed;
    logic [CW-1:0]     total_ext;
    logic [CW-1:0]     slot_limit;
    logic [CW-1:0]     slot_inc;
    logic [SLOT_W-1:0] wslot;
    logic [SX_W-1:0]   wslot_ext;
    logic [SX_W-1:0]   oldest_ext;

    trs_trigger_cmp u_cmp (
        .compare_type (cfg.compare_type),
        .value        (trig),
        .threshold    (cfg.threshold),
        .at_or_above  (at_or_above)
    );

    assign crossed   = (cfg.trigger_mode == MODE_FALLING) ? !at_or_above : at_or_above;
    assign total_ext = CW'(cfg.total_samples);
    assign slot_inc  = CW'(next_slot_reg) + CW'(1);

    always_comb begin
        if (cfg.total_samples == '0) begin
            slot_limit = CW'(1);
        end else if (total_ext > CW'(SLOT_COUNT)) begin
            slot_limit = CW'(SLOT_COUNT);
        end else begin
            slot_limit = total_ext;
        end
    end

    always_comb begin
        next_slot_next      = next_slot_reg;
        divider_count_next  = divider_count_reg;
        stop_countdown_next = stop_countdown_reg;
        running_next        = running_reg;
        stopping_next       = stopping_reg;
        below_seen_next     = below_seen_reg;
        first_pass_next     = first_pass_reg;
        res.status          = ST_OK;
        res.write_enable    = 1'b0;
        res.write_data      = '0;
        wslot               = '0;

        if (step_en) begin
            unique case (func_t'(func))
                FUNC_START: begin
                    if (!cfg.configured) begin
                        res.status = ST_NOT_CFG;
                    end else if (running_reg) begin
                        res.status = ST_RUNNING;
                    end else begin
                        next_slot_next     = '0;
                        divider_count_next = '0;
                        stopping_next      = 1'b0;
                        below_seen_next    = 1'b0;
                        first_pass_next    = 1'b1;
                        running_next       = 1'b1;
                    end
                end
                FUNC_STOP: begin
                    if (!cfg.configured) begin
                        res.status = ST_NOT_CFG;
                    end else if (!running_reg) begin
                        res.status = ST_STOPPED;
                    end else if (!stopping_reg) begin
                        stopping_next       = 1'b1;
                        stop_countdown_next = cfg.post_trigger;
                    end
                end
                FUNC_TICK: begin
                    if (running_reg) begin
                        if (divider_count_reg != '0) begin
                            divider_count_next = divider_count_reg - 16'd1;
                        end else begin
                            divider_count_next = cfg.time_div;
                            res.write_enable   = 1'b1;
                            res.write_data     = DATA_W'(sample);
                            wslot              = next_slot_reg;
                            if (slot_inc >= slot_limit) begin
                                next_slot_next  = '0;
                                first_pass_next = 1'b0;
                            end else begin
                                next_slot_next  = slot_inc[SLOT_W-1:0];
                            end
                            if (!first_pass_next) begin
                                if (!stopping_reg && cfg.trigger_mode != MODE_NONE) begin
                                    if (crossed) begin
                                        if (below_seen_reg) begin
                                            stopping_next       = 1'b1;
                                            stop_countdown_next = cfg.post_trigger;
                                        end
                                    end else begin
                                        below_seen_next = 1'b1;
                                    end
                                end
                                if (stopping_next) begin
                                    if (stop_countdown_next == '0) begin
                                        running_next = 1'b0;
                                    end else begin
                                        stop_countdown_next = stop_countdown_next - 16'd1;
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        wslot_ext        = SX_W'(wslot);
        oldest_ext       = SX_W'(next_slot_next);
        res.write_slot   = wslot_ext[SLOT_FIELD_W-1:0];
        res.oldest_slot  = oldest_ext[SLOT_FIELD_W-1:0];
        res.is_running   = running_next;
        res.is_triggered = stopping_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_slot_reg      <= '0;
            divider_count_reg  <= '0;
            stop_countdown_reg <= '0;
            running_reg        <= 1'b0;
            stopping_reg       <= 1'b0;
            below_seen_reg     <= 1'b0;
            first_pass_reg     <= 1'b0;
        end else begin
            next_slot_reg      <= next_slot_next;
            divider_count_reg  <= divider_count_next;
            stop_countdown_reg <= stop_countdown_next;
            running_reg        <= running_next;
            stopping_reg       <= stopping_next;
            below_seen_reg     <= below_seen_next;
            first_pass_reg     <= first_pass_next;
        end
    end

    `TRS_ASSERT(a_slot_in_range, aclk, aresetn, CW'(next_slot_reg) < CW'(SLOT_COUNT))
    `TRS_ASSERT_NEVER(a_write_only_running, aclk, aresetn, res.write_enable && !running_reg)
    `TRS_ASSERT(a_stop_after_trigger, aclk, aresetn,
        $fell(running_reg) && $past(aresetn) |-> stopping_reg)
    `TRS_ASSERT(a_start_arms, aclk, aresetn,
        step_en && func == FUNC_START && res.status == ST_OK
        |=> running_reg && first_pass_reg && !stopping_reg && next_slot_reg == '0)

endmodule
